// ===== hw/rtl/ptw_pkg.sv =====
// ============================================================================
// Page table walker package
// Shared constants, request codes and the response payload type.
// ============================================================================
package ptw_pkg;

   localparam int MEM_WORDS_DEF = 4096;

   localparam int OP_W       = 1;
   localparam int WADDR_W    = 12;
   localparam int WORD_W     = 64;
   localparam int ROOT_W     = 52;
   localparam int VA_W       = 48;
   localparam int FLAG_W     = 12;
   localparam int IDX_W      = 9;
   localparam int LEVELS     = 4;
   localparam int LVL_W      = 2;
   localparam int FRAME_LO   = 12;
   localparam int FRAME_HI   = 51;
   localparam int FRAME_W    = FRAME_HI - FRAME_LO + 1;
   localparam int TWORD_W    = FRAME_W + IDX_W;
   localparam int FLAGS_W    = FLAG_W * LEVELS;

   // Entry bit positions.
   localparam int PTE_P_BIT  = 0;
   localparam int PTE_U_BIT  = 2;
   localparam int PTE_PS_BIT = 7;

   // Request operation codes.
   localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
   localparam logic [OP_W-1:0] OP_WALK  = 1'b1;

   // Level numbers as counted by the walker (top table is level zero).
   localparam logic [LVL_W-1:0] LVL_PD = 2'd2;
   localparam logic [LVL_W-1:0] LVL_PT = 2'd3;

   typedef struct packed {
      logic               mapped;
      logic               user_ok;
      logic [FLAGS_W-1:0] walk_flags;
      logic               out_of_range;
   } ptw_rsp_type;

endpackage

// ===== hw/rtl/ptw_ifs.sv =====
// ============================================================================
// Page table walker channels
// Valid/ready interfaces for the request and the response channel.
// ============================================================================
interface ptw_req_if;
   import ptw_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [WADDR_W-1:0] word_addr;
   logic [WORD_W-1:0]  word_data;
   logic [ROOT_W-1:0]  root_addr;
   logic [VA_W-1:0]    vaddr;

   modport source (output valid, op, word_addr, word_data, root_addr, vaddr,
                   input ready);
   modport sink   (input valid, op, word_addr, word_data, root_addr, vaddr,
                   output ready);
endinterface

interface ptw_rsp_if;
   import ptw_pkg::*;

   logic               valid;
   logic               ready;
   logic               mapped;
   logic               user_ok;
   logic [FLAGS_W-1:0] walk_flags;
   logic               out_of_range;

   modport source (output valid, mapped, user_ok, walk_flags, out_of_range,
                   input ready);
   modport sink   (input valid, mapped, user_ok, walk_flags, out_of_range,
                   output ready);
endinterface

// ===== hw/rtl/ptw_mem.sv =====
// ============================================================================
// Page table memory
// Single-port-write, single-port-read table store with registered read data.
// ============================================================================
module ptw_mem #(
   parameter int MEM_WORDS = ptw_pkg::MEM_WORDS_DEF,
   parameter int AW        = $clog2(MEM_WORDS)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [ptw_pkg::WORD_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [ptw_pkg::WORD_W-1:0] rd_data
);
   import ptw_pkg::*;

   logic [WORD_W-1:0] mem [MEM_WORDS];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ptw_ctrl.sv =====
// ============================================================================
// Page table walker control
// Takes requests, drives the table memory and steps through the four levels.
// ============================================================================
module ptw_ctrl #(
   parameter int MEM_WORDS = ptw_pkg::MEM_WORDS_DEF,
   parameter int AW        = $clog2(MEM_WORDS)
) (
   input  logic                       clock,
   input  logic                       reset,
   ptw_req_if.sink                    req_bus,
   output logic                       wr_en,
   output logic [AW-1:0]              wr_addr,
   output logic [ptw_pkg::WORD_W-1:0] wr_data,
   output logic                       rd_en,
   output logic [AW-1:0]              rd_addr,
   input  logic [ptw_pkg::WORD_W-1:0] rd_data,
   output logic                       res_valid,
   input  logic                       res_ready,
   output ptw_pkg::ptw_rsp_type       res_out
);
   import ptw_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   logic [VA_W-1:0]    va_ff, va_in;
   logic [FLAGS_W-1:0] flags_ff, flags_in;
   logic               user_all_ff, user_all_in;
   ptw_rsp_type        hold_ff, hold_in;

   logic [FRAME_W-1:0] tbl_frame;
   logic [IDX_W-1:0]   tbl_idx;
   logic [TWORD_W-1:0] tbl_word;
   logic               tbl_oor;
   logic [FLAGS_W-1:0] flags_cur;
   logic               user_cur;
   logic               finish;
   ptw_rsp_type        res_nxt;

   // Nine-bit table index of the given level, top table first.
   function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                 input logic [LVL_W-1:0] lvl);
      logic [IDX_W-1:0] idx;
      case (lvl)
         2'd0:    idx = va[47:39];
         2'd1:    idx = va[38:30];
         2'd2:    idx = va[29:21];
         default: idx = va[20:12];
      endcase
      return idx;
   endfunction

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign wr_addr       = AW'(req_bus.word_addr);
   assign wr_data       = req_bus.word_data;

   // Word address of the next entry: frame number concatenated with the index.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         tbl_frame = req_bus.root_addr[FRAME_HI:FRAME_LO];
         tbl_idx   = va_index(req_bus.vaddr, '0);
      end else begin
         tbl_frame = rd_data[FRAME_HI:FRAME_LO];
         tbl_idx   = va_index(va_ff, lvl_ff + 1'b1);
      end
      tbl_word = {tbl_frame, tbl_idx};
      tbl_oor  = (tbl_word >= TWORD_W'(MEM_WORDS));
   end

   assign rd_addr = tbl_word[AW-1:0];

   always_comb begin
      flags_cur = flags_ff;
      flags_cur[lvl_ff*FLAG_W +: FLAG_W] = rd_data[FLAG_W-1:0];
      user_cur = user_all_ff & rd_data[PTE_U_BIT];
   end

   always_comb begin
      state_in    = state_ff;
      lvl_in      = lvl_ff;
      va_in       = va_ff;
      flags_in    = flags_ff;
      user_all_in = user_all_ff;
      hold_in     = hold_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      res_valid   = 1'b0;
      res_out     = hold_ff;
      finish      = 1'b0;
      res_nxt     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.op == OP_WRITE) begin
                  wr_en  = (32'(req_bus.word_addr) < MEM_WORDS);
                  finish = 1'b1;
               end else begin
                  va_in       = req_bus.vaddr;
                  flags_in    = '0;
                  user_all_in = 1'b1;
                  lvl_in      = '0;
                  if (tbl_oor) begin
                     finish               = 1'b1;
                     res_nxt.out_of_range = 1'b1;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = ST_WALK;
                  end
               end
            end
         end
         ST_WALK: begin
            flags_in           = flags_cur;
            user_all_in        = user_cur;
            res_nxt.walk_flags = flags_cur;
            if (!rd_data[PTE_P_BIT]) begin
               finish = 1'b1;
            end else if (lvl_ff == LVL_PT || (lvl_ff == LVL_PD && rd_data[PTE_PS_BIT])) begin
               finish          = 1'b1;
               res_nxt.mapped  = 1'b1;
               res_nxt.user_ok = user_cur;
            end else if (tbl_oor) begin
               finish               = 1'b1;
               res_nxt.out_of_range = 1'b1;
            end else begin
               rd_en  = 1'b1;
               lvl_in = lvl_ff + 1'b1;
            end
         end
         ST_HOLD: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A finished result goes straight to the output stage when it has room.
      if (finish) begin
         res_valid = 1'b1;
         res_out   = res_nxt;
         if (res_ready) begin
            state_in = ST_IDLE;
         end else begin
            state_in = ST_HOLD;
            hold_in  = res_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff      <= lvl_in;
      va_ff       <= va_in;
      flags_ff    <= flags_in;
      user_all_ff <= user_all_in;
      hold_ff     <= hold_in;
   end

endmodule

// ===== hw/rtl/four_level_page_table_walker.sv =====
// ============================================================================
// Four-level page table walker
// Table memory loaded by write requests, walked by translation requests.
// ============================================================================
// Every request produces exactly one response. A write request (op = 0) stores
// one 64-bit entry at word_addr and answers with all fields zero; a write at or
// beyond MEM_WORDS is dropped. A walk request (op = 1) reads up to four entries,
// using virtual address bits 47:39, 38:30, 29:21 and 20:12 as indices and each
// entry's bits 51:12 as the next table's base. Every walk step is one read of
// the table memory, which registers its read data, and each read depends on the
// entry returned by the previous one, so a walk request keeps the block busy
// until its last read has returned; a write request or a walk whose root lies
// outside memory finishes in the cycle it is taken. A new request is taken
// once the previous one has handed its response to the output register, which
// holds it until the consumer takes it.
// Reading a table word that was never written gives an undefined response.
// ============================================================================
module four_level_page_table_walker #(
   parameter int MEM_WORDS = ptw_pkg::MEM_WORDS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ptw_req_if.sink    req_bus,
   ptw_rsp_if.source  rsp_bus
);
   import ptw_pkg::*;

   localparam int AW = $clog2(MEM_WORDS);

   // Memory port signals between the controller and the table store.
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [WORD_W-1:0] rd_data;

   // Finished result offered by the controller.
   logic              res_valid;
   logic              res_ready;
   ptw_rsp_type       res_out;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   ptw_rsp_type       rsp_data_ff;

   ptw_mem #(
      .MEM_WORDS (MEM_WORDS),
      .AW        (AW)
   ) u_ptw_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ptw_ctrl #(
      .MEM_WORDS (MEM_WORDS),
      .AW        (AW)
   ) u_ptw_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_out   (res_out)
   );

   // The output register can take a new result when it is empty or is being
   // emptied in this cycle.
   assign res_ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res_out;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.mapped       = rsp_data_ff.mapped;
   assign rsp_bus.user_ok      = rsp_data_ff.user_ok;
   assign rsp_bus.walk_flags   = rsp_data_ff.walk_flags;
   assign rsp_bus.out_of_range = rsp_data_ff.out_of_range;

endmodule

// ===== hw/rtl/ptw_checker.sv =====
// ============================================================================
// Page table walker checker
// Port-level assertions on the walker, attached to the top level by bind.
// ============================================================================
module ptw_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_mapped,
   input logic                        rsp_user_ok,
   input logic [ptw_pkg::FLAGS_W-1:0] rsp_walk_flags,
   input logic                        rsp_out_of_range
);
   import ptw_pkg::*;

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mapped)
         && $stable(rsp_user_ok) && $stable(rsp_walk_flags) && $stable(rsp_out_of_range))
      else $error("response changed while stalled");

   // A request taken while the output is full and stalled leaves the block busy.
   a_busy_when_full: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_valid && !rsp_ready |=> !req_ready)
      else $error("walker took a request with no room for its response");

   // User access is only reported for a mapped address.
   a_user_mapped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_user_ok |-> rsp_mapped)
      else $error("user_ok without mapped");

   // A mapping needs present upper levels and never an out-of-range stop.
   a_mapped_present: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mapped |-> !rsp_out_of_range && rsp_walk_flags[0]
         && rsp_walk_flags[FLAG_W] && rsp_walk_flags[2*FLAG_W])
      else $error("mapped response with a non-present upper level");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_mapped       (rsp_bus.mapped),
   .rsp_user_ok      (rsp_bus.user_ok),
   .rsp_walk_flags   (rsp_bus.walk_flags),
   .rsp_out_of_range (rsp_bus.out_of_range)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Four-level page table walker testbench
// Loads table words through write requests and checks every response against
// a model of the table memory kept inside the bench or a hand-written answer.
// ============================================================================
module tb;
   import ptw_pkg::*;

   localparam int MEM_WORDS     = MEM_WORDS_DEF;
   localparam int RESET_CYCLES  = 10;
   localparam int RANDOM_ITEMS  = 900;
   localparam int DRAIN_CYCLES  = 20;
   localparam int LIMIT_CYCLES  = 200000;
   localparam int DIR_N         = 22;

   localparam logic [63:0] FRAME_MASK = 64'h000F_FFFF_FFFF_F000;
   localparam logic [63:0] IDX_MASK   = (64'd1 << IDX_W) - 1;
   localparam logic [63:0] FLAG_MASK  = (64'd1 << FLAG_W) - 1;
   // Shift that brings the top-level index down to bit zero.
   localparam int TOP_SHIFT = FRAME_LO + IDX_W * (LEVELS - 1);

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [WADDR_W-1:0] word_addr;
      logic [WORD_W-1:0]  word_data;
      logic [ROOT_W-1:0]  root_addr;
      logic [VA_W-1:0]    vaddr;
   } ptw_req_item_type;

   // One line of the directed table: the request, and a hand-written response
   // where the answer is obvious. Other lines take the predicted response.
   typedef struct packed {
      ptw_req_item_type req;
      logic             typed;
      ptw_rsp_type      want;
   } dir_row_type;

   localparam ptw_rsp_type NO_RESULT   = '0;
   localparam ptw_rsp_type OOR_AT_ROOT = '{1'b0, 1'b0, {FLAGS_W{1'b0}}, 1'b1};

   logic clock;
   logic reset;

   ptw_req_if req_bus ();
   ptw_rsp_if rsp_bus ();

   four_level_page_table_walker #(
      .MEM_WORDS (MEM_WORDS)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Shadow copy of the table memory, with a flag for every word that has been
   // written. A walk that would touch an unwritten word is never sent, because
   // the block's answer to it is undefined.
   logic [WORD_W-1:0] pt_words   [MEM_WORDS];
   bit                pt_written [MEM_WORDS];

   ptw_rsp_type rsp_expect_q [$];

   int unsigned mismatches    = 0;
   int unsigned requests_sent = 0;
   int unsigned cycle_count   = 0;
   int unsigned req_calm      = 0;
   int unsigned rsp_calm      = 0;

   // The directed table. The translation chain lives at the last entry of
   // tables 4, 5, 6 and 7, so virtual address all ones under root 0x4000
   // walks words 2559, 3071, 3583 and 4095.
   dir_row_type directed_rows [DIR_N] = '{
      // Root with every bit set lies far outside the table memory.
      '{'{OP_WALK, 12'd0, 64'd0, 52'hF_FFFF_FFFF_FFFF, 48'd0}, 1'b1, OOR_AT_ROOT},
      // Root in the first table just past the end of memory.
      '{'{OP_WALK, 12'd0, 64'd0, 52'h0_0000_0000_8000, 48'hFFFF_FFFF_FFFF},
        1'b1, OOR_AT_ROOT},
      // Top entry with bit 63 set and a page size bit, which the top level ignores.
      '{'{OP_WRITE, 12'd2559, 64'h8000_0000_0000_5087, 52'd0, 48'd0}, 1'b1, NO_RESULT},
      '{'{OP_WRITE, 12'd3071, 64'h0000_0000_0000_6007, 52'd0, 48'd0}, 1'b1, NO_RESULT},
      '{'{OP_WRITE, 12'd3583, 64'h0000_0000_0000_7007, 52'd0, 48'd0}, 1'b1, NO_RESULT},
      '{'{OP_WRITE, 12'd4095, 64'hFFFF_FFFF_FFFF_FFFF, 52'd0, 48'd0}, 1'b1, NO_RESULT},
      // Full four-level walk; the low root bits must be ignored.
      '{'{OP_WALK, 12'd0, 64'd0, 52'h0_0000_0000_4FFF, 48'hFFFF_FFFF_FFFF}, 1'b0, '0},
      '{'{OP_WRITE, 12'd0, 64'd0, 52'd0, 48'd0}, 1'b1, NO_RESULT},
      // A zero top entry is not present and carries no flags.
      '{'{OP_WALK, 12'd0, 64'd0, 52'd0, 48'd0}, 1'b1, NO_RESULT},
      // Large page at the page directory level.
      '{'{OP_WRITE, 12'd3583, 64'h0000_0000_0000_7087, 52'd0, 48'd0}, 1'b1, NO_RESULT},
      '{'{OP_WALK, 12'd0, 64'd0, 52'h0_0000_0000_4000, 48'hFFFF_FFFF_FFFF}, 1'b0, '0},
      // Present but supervisor-only at the second level.
      '{'{OP_WRITE, 12'd3071, 64'h0000_0000_0000_6003, 52'd0, 48'd0}, 1'b1, NO_RESULT},
      '{'{OP_WRITE, 12'd3583, 64'h0000_0000_0000_7007, 52'd0, 48'd0}, 1'b1, NO_RESULT},
      '{'{OP_WALK, 12'd0, 64'd0, 52'h0_0000_0000_4000, 48'hFFFF_FFFF_FFFF}, 1'b0, '0},
      // Final entry not present.
      '{'{OP_WRITE, 12'd4095, 64'hFFFF_FFFF_FFFF_FFFE, 52'd0, 48'd0}, 1'b1, NO_RESULT},
      '{'{OP_WALK, 12'd0, 64'd0, 52'h0_0000_0000_4000, 48'hFFFF_FFFF_FFFF}, 1'b0, '0},
      // Second level not present: the walk stops there.
      '{'{OP_WRITE, 12'd3071, 64'h0000_0000_0000_6006, 52'd0, 48'd0}, 1'b1, NO_RESULT},
      '{'{OP_WALK, 12'd0, 64'd0, 52'h0_0000_0000_4000, 48'hFFFF_FFFF_FFFF}, 1'b0, '0},
      // Second level points at a huge frame, so the third read is out of range.
      '{'{OP_WRITE, 12'd3071, 64'hFFFF_FFFF_FFFF_FFFF, 52'd0, 48'd0}, 1'b1, NO_RESULT},
      '{'{OP_WALK, 12'd0, 64'd0, 52'h0_0000_0000_4000, 48'hFFFF_FFFF_FFFF}, 1'b0, '0},
      // Same, with the first frame just past the end of memory.
      '{'{OP_WRITE, 12'd3071, 64'h0000_0000_0000_8007, 52'd0, 48'd0}, 1'b1, NO_RESULT},
      '{'{OP_WALK, 12'd0, 64'd0, 52'h0_0000_0000_4000, 48'hFFFF_FFFF_FFFF}, 1'b0, '0}
   };

   // Computes the response to one request and applies a write to the shadow
   // memory. hits_unwritten tells whether a walk would read an unwritten word.
   function automatic ptw_rsp_type predict_translation(input ptw_req_item_type item,
                                                       output bit hits_unwritten);
      ptw_rsp_type rsp;
      logic [63:0] base;
      logic [63:0] entry;
      logic [63:0] word_idx;
      logic [63:0] flags;
      bit          user_all;
      bit          done;
      rsp            = '0;
      hits_unwritten = 1'b0;
      flags          = '0;
      user_all       = 1'b1;
      done           = 1'b0;
      base           = 64'(item.root_addr);
      if (item.op == OP_WRITE) begin
         if (int'(item.word_addr) < MEM_WORDS) begin
            pt_words[item.word_addr]   = item.word_data;
            pt_written[item.word_addr] = 1'b1;
         end
      end else begin
         for (int lvl = 0; lvl < LEVELS && !done; lvl++) begin
            word_idx = ((base & FRAME_MASK) >> 3)
                     + ((64'(item.vaddr) >> (TOP_SHIFT - IDX_W * lvl)) & IDX_MASK);
            if (word_idx >= 64'(MEM_WORDS)) begin
               rsp.out_of_range = 1'b1;
               done = 1'b1;
            end else begin
               if (!pt_written[word_idx]) begin
                  hits_unwritten = 1'b1;
               end
               entry = pt_words[word_idx];
               flags |= (entry & FLAG_MASK) << (FLAG_W * lvl);
               if (!entry[PTE_P_BIT]) begin
                  done = 1'b1;
               end else begin
                  if (!entry[PTE_U_BIT]) begin
                     user_all = 1'b0;
                  end
                  if (lvl == int'(LVL_PT) || (lvl == int'(LVL_PD) && entry[PTE_PS_BIT])) begin
                     rsp.mapped  = 1'b1;
                     rsp.user_ok = user_all;
                     done = 1'b1;
                  end
                  base = entry;
               end
            end
         end
         rsp.walk_flags = flags[FLAGS_W-1:0];
      end
      return rsp;
   endfunction

   // Idle cycles before the next handshake. Now and then a side enters a calm
   // stretch in which it never idles.
   function automatic int unsigned draw_wait(inout int unsigned calm_left);
      if (calm_left != 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 31) == 0) begin
         calm_left = $urandom_range(20, 40);
         return 0;
      end
      return $urandom_range(0, 6);
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, want, got);
      end
   endfunction

   // Presents one request, waits for it to be taken and records the response
   // it must produce. Called right after a rising edge.
   task automatic issue_request(input ptw_req_item_type item, input ptw_rsp_type want);
      int unsigned gap;
      gap = draw_wait(req_calm);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.op        <= item.op;
      req_bus.word_addr <= item.word_addr;
      req_bus.word_data <= item.word_data;
      req_bus.root_addr <= item.root_addr;
      req_bus.vaddr     <= item.vaddr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      rsp_expect_q.push_back(want);
      requests_sent++;
   endtask

   task automatic issue_write(input logic [WADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
      ptw_req_item_type item;
      ptw_rsp_type      want;
      bit               unwritten;
      // Walk fields carry junk on a write; the block must ignore them.
      item.op        = OP_WRITE;
      item.word_addr = addr;
      item.word_data = data;
      item.root_addr = ROOT_W'({$urandom(), $urandom()});
      item.vaddr     = VA_W'({$urandom(), $urandom()});
      want = predict_translation(item, unwritten);
      issue_request(item, want);
   endtask

   // Sends a walk only if every word it reads has been written.
   task automatic issue_walk(input logic [ROOT_W-1:0] root, input logic [VA_W-1:0] va);
      ptw_req_item_type item;
      ptw_rsp_type      want;
      bit               unwritten;
      item.op        = OP_WALK;
      item.word_addr = WADDR_W'($urandom());
      item.word_data = {$urandom(), $urandom()};
      item.root_addr = root;
      item.vaddr     = va;
      want = predict_translation(item, unwritten);
      if (!unwritten) begin
         issue_request(item, want);
      end
   endtask

   // Builds a complete chain of four entries for a random virtual address,
   // then walks it. Table base words are frame * 512, so the word address of
   // an entry is the frame's low three bits followed by the 9-bit index.
   task automatic map_and_walk();
      logic [VA_W-1:0]   va;
      logic [VA_W-1:0]   va_near;
      logic [ROOT_W-1:0] root;
      logic [39:0]       cur_frame;
      logic [39:0]       next_frame;
      logic [11:0]       flags12;
      logic [IDX_W-1:0]  idx;
      va        = VA_W'({$urandom(), $urandom()});
      cur_frame = 40'($urandom_range(0, 7));
      root      = {cur_frame, 12'($urandom())};
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         idx = va[VA_W-1-IDX_W*lvl -: IDX_W];
         if ($urandom_range(0, 19) == 0) begin
            next_frame = 40'({$urandom(), $urandom()}) | 40'd8;
         end else begin
            next_frame = 40'($urandom_range(0, 7));
         end
         flags12    = 12'($urandom());
         flags12[PTE_P_BIT] = ($urandom_range(0, 9) != 0);
         flags12[PTE_U_BIT] = ($urandom_range(0, 4) != 0);
         if (lvl == int'(LVL_PD)) begin
            flags12[PTE_PS_BIT] = ($urandom_range(0, 9) < 3);
         end
         issue_write({cur_frame[2:0], idx}, {12'($urandom()), next_frame, flags12});
         cur_frame = next_frame;
      end
      issue_walk(root, va);
      if ($urandom_range(0, 1) == 1) begin
         // A neighbor: other page offset, sometimes another last-level index.
         va_near = va;
         va_near[11:0] = 12'($urandom());
         if ($urandom_range(0, 1) == 1) begin
            va_near[20:12] = 9'($urandom());
         end
         issue_walk(root, va_near);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Response side: stalls at random, then compares each response it takes
   // with the oldest expected one.
   initial begin : response_side
      ptw_rsp_type want;
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(rsp_calm);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         if (rsp_expect_q.size() == 0) begin
            mismatches++;
            $display("%0t: response with no request outstanding, expected none, actual 0x%0h",
                     $time, {rsp_bus.mapped, rsp_bus.user_ok, rsp_bus.walk_flags,
                             rsp_bus.out_of_range});
         end else begin
            want = rsp_expect_q.pop_front();
            check_field("mapped", 64'(want.mapped), 64'(rsp_bus.mapped));
            check_field("user_ok", 64'(want.user_ok), 64'(rsp_bus.user_ok));
            check_field("walk_flags", 64'(want.walk_flags), 64'(rsp_bus.walk_flags));
            check_field("out_of_range", 64'(want.out_of_range), 64'(rsp_bus.out_of_range));
         end
      end
   end

   // Request side: reset, the directed table, then random traffic.
   initial begin : request_side
      ptw_rsp_type predicted;
      bit          unwritten;
      int unsigned pick;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.op        <= OP_WRITE;
      req_bus.word_addr <= '0;
      req_bus.word_data <= '0;
      req_bus.root_addr <= '0;
      req_bus.vaddr     <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int row = 0; row < DIR_N; row++) begin
         // Writes still go through the predictor so the shadow memory follows.
         predicted = predict_translation(directed_rows[row].req, unwritten);
         issue_request(directed_rows[row].req,
                       directed_rows[row].typed ? directed_rows[row].want : predicted);
      end

      // Mostly complete chains with random content, plus stray writes and
      // walks from random roots, many of which fall outside the memory.
      while (requests_sent < DIR_N + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            map_and_walk();
         end else if (pick < 85) begin
            issue_write(WADDR_W'($urandom()), {$urandom(), $urandom()});
         end else if ($urandom_range(0, 1) == 1) begin
            issue_walk(ROOT_W'({$urandom(), $urandom()}), VA_W'({$urandom(), $urandom()}));
         end else begin
            issue_walk(ROOT_W'({$urandom_range(0, 7), 12'($urandom())}),
                       VA_W'({$urandom(), $urandom()}));
         end
      end
      req_bus.valid <= 1'b0;

      while (rsp_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/ptw_pkg.sv
hw/rtl/ptw_ifs.sv
hw/rtl/ptw_mem.sv
hw/rtl/ptw_ctrl.sv
hw/rtl/four_level_page_table_walker.sv
hw/rtl/ptw_checker.sv
tb/sv/tb.sv
